// ----- hdl/bpnc_pkg.sv -----
// ============================================================================
// bpnc_pkg
// Shared types and constants for the blended palette nearest colour unit.
// ============================================================================
package bpnc_pkg;

   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COMP_W  = 8;
   localparam int unsigned SQ_W    = 2 * COMP_W;
   // worst case is 256 * 255^2, well inside 25 bits
   localparam int unsigned DIST_W  = 25;

   localparam logic [7:0] WEIGHT_R = 8'd54;
   localparam logic [7:0] WEIGHT_G = 8'd183;
   localparam logic [7:0] WEIGHT_B = 8'd19;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // blend modes
   localparam logic BLEND_HALF    = 1'b0;
   localparam logic BLEND_QUARTER = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] r;
      logic [COMP_W-1:0] g;
      logic [COMP_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } dist_result_type;

endpackage

// ----- hdl/blended_palette_nearest_color_unit.sv -----
// ============================================================================
// blended_palette_nearest_color_unit
// Palette store with a blended-colour nearest-entry search.
// ============================================================================
// Usage:
//  - Request channel (req_*): req_kind selects a load (writes one palette
//    entry from req_red/green/blue at req_entry_index) or a query (blends
//    req_first_color and req_second_color per req_blend_mode, then finds the
//    nearest palette entry by weighted squared RGB distance, 54/183/19).
//  - Response channel (rsp_*): one rsp_nearest_color per query, none for loads.
//  - Loads return nothing; out-of-range loads are dropped.
//  - A query naming the same colour twice answers with that colour
//    without a search.
//  - A search makes two palette reads for the blend, then one palette read
//    per entry through the single read port of the store, then the distance
//    pipe drains. One request at a time.
//  - A finished result sits in an output register; the next request is taken
//    while it waits. rsp_stall holds the result; a second result waits inside
//    until the register frees.
//  - Reset clears the controller and the response valid; palette contents
//    are undefined until loaded.
// ============================================================================
module blended_palette_nearest_color_unit #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_entry_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_first_color,
   input  logic [7:0] req_second_color,
   input  logic       req_blend_mode,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_nearest_color
);

   localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);
   localparam logic [8:0]    ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

   // controller states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RD_A   = 3'd1;
   localparam logic [2:0] ST_RD_B   = 3'd2;
   localparam logic [2:0] ST_BLEND  = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]              state_ff, state_in;

   // palette store, one write and one registered read port
   bpnc_pkg::rgb_type       palette_mem [PALETTE_ENTRIES];
   bpnc_pkg::rgb_type       rd_data_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;

   // latched query
   logic [AW-1:0]           first_addr_ff, second_addr_ff;
   logic                    first_oob_ff, second_oob_ff;
   logic                    blend_mode_ff;
   bpnc_pkg::rgb_type       color_a_ff;
   bpnc_pkg::rgb_type       target_ff, target_in;

   // scan
   logic [AW-1:0]           scan_idx_ff;
   logic                    p1_valid_ff;
   logic [AW-1:0]           p1_idx_ff;
   logic                    dist_busy;
   bpnc_pkg::dist_result_type dist_res;
   logic [bpnc_pkg::DIST_W-1:0] best_dist_ff;
   logic [7:0]              best_ff;

   // output register
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_color_ff;
   logic                    out_free;

   logic                    req_accept;
   logic                    same_color;
   bpnc_pkg::rgb_type       color_b;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign same_color = (req_first_color == req_second_color);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign wr_en      = req_accept && (req_kind == bpnc_pkg::KIND_LOAD)
                       && ({1'b0, req_entry_index} < ENTRY_LIMIT);

   // read address mux
   always_comb begin
      case (state_ff)
         ST_RD_A: rd_addr = first_addr_ff;
         ST_RD_B: rd_addr = second_addr_ff;
         default: rd_addr = scan_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[req_entry_index[AW-1:0]] <= {req_red, req_green, req_blue};
      end
      rd_data_ff <= palette_mem[rd_addr];
   end

   // blend; out-of-range indexes read as black
   function automatic logic [7:0] blend_comp(input logic [7:0] a, input logic [7:0] b,
                                             input logic quarter);
      logic [9:0] sum;
      begin
         if (quarter == bpnc_pkg::BLEND_QUARTER) begin
            sum = 10'(a) + 10'(b) + 10'(b) + 10'(b);
            blend_comp = sum[9:2];
         end else begin
            sum = 10'(a) + 10'(b);
            blend_comp = sum[8:1];
         end
      end
   endfunction

   always_comb begin
      color_b     = second_oob_ff ? '0 : rd_data_ff;
      target_in.r = blend_comp(color_a_ff.r, color_b.r, blend_mode_ff);
      target_in.g = blend_comp(color_a_ff.g, color_b.g, blend_mode_ff);
      target_in.b = blend_comp(color_a_ff.b, color_b.b, blend_mode_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_kind == bpnc_pkg::KIND_QUERY) begin
               state_in = same_color ? ST_FINISH : ST_RD_A;
            end
         end
         ST_RD_A:  state_in = ST_RD_B;
         ST_RD_B:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_idx_ff == LAST_ENTRY) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !dist_busy && !dist_res.valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         first_addr_ff  <= req_first_color[AW-1:0];
         second_addr_ff <= req_second_color[AW-1:0];
         first_oob_ff   <= !({1'b0, req_first_color} < ENTRY_LIMIT);
         second_oob_ff  <= !({1'b0, req_second_color} < ENTRY_LIMIT);
         blend_mode_ff  <= req_blend_mode;
      end
      if (state_ff == ST_RD_B) begin
         color_a_ff <= first_oob_ff ? '0 : rd_data_ff;
      end
      if (state_ff == ST_BLEND) begin
         target_ff <= target_in;
      end
      if (state_ff == ST_SCAN) begin
         scan_idx_ff <= scan_idx_ff + AW'(1);
      end else begin
         scan_idx_ff <= '0;
      end
      p1_idx_ff <= scan_idx_ff;
      // running minimum, first entry always taken, ties keep the lower index
      if (state_ff == ST_IDLE && req_accept) begin
         best_ff <= req_first_color;
      end else if (dist_res.valid) begin
         if (dist_res.index == '0 || dist_res.distance < best_dist_ff) begin
            best_dist_ff <= dist_res.distance;
            best_ff      <= dist_res.index;
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_color_ff <= best_ff;
      end
   end

   bpnc_dist_pipe u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (p1_valid_ff),
      .in_index (bpnc_pkg::INDEX_W'(p1_idx_ff)),
      .entry    (rd_data_ff),
      .target   (target_ff),
      .busy     (dist_busy),
      .result   (dist_res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_color = rsp_color_ff;

endmodule

// ----- hdl/bpnc_dist_pipe.sv -----
// ============================================================================
// bpnc_dist_pipe
// Two-stage weighted squared distance: squares, then weighted sum.
// ============================================================================
module bpnc_dist_pipe (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [bpnc_pkg::INDEX_W-1:0]   in_index,
   input  bpnc_pkg::rgb_type              entry,
   input  bpnc_pkg::rgb_type              target,
   output logic                           busy,
   output bpnc_pkg::dist_result_type      result
);

   logic                          s1_valid_ff;
   logic [bpnc_pkg::INDEX_W-1:0]  s1_index_ff;
   logic [bpnc_pkg::SQ_W-1:0]     sq_r_ff, sq_g_ff, sq_b_ff;
   logic [bpnc_pkg::SQ_W-1:0]     sq_r_in, sq_g_in, sq_b_in;
   logic [bpnc_pkg::COMP_W-1:0]   d_r, d_g, d_b;

   logic                          s2_valid_ff;
   logic [bpnc_pkg::INDEX_W-1:0]  s2_index_ff;
   logic [bpnc_pkg::DIST_W-1:0]   dist_ff, dist_in;

   // absolute differences, then squares
   always_comb begin
      d_r = (entry.r >= target.r) ? (entry.r - target.r) : (target.r - entry.r);
      d_g = (entry.g >= target.g) ? (entry.g - target.g) : (target.g - entry.g);
      d_b = (entry.b >= target.b) ? (entry.b - target.b) : (target.b - entry.b);
      sq_r_in = bpnc_pkg::SQ_W'(d_r) * bpnc_pkg::SQ_W'(d_r);
      sq_g_in = bpnc_pkg::SQ_W'(d_g) * bpnc_pkg::SQ_W'(d_g);
      sq_b_in = bpnc_pkg::SQ_W'(d_b) * bpnc_pkg::SQ_W'(d_b);
   end

   // weights are constants, the sum fits DIST_W
   always_comb begin
      dist_in = bpnc_pkg::DIST_W'(sq_r_ff) * bpnc_pkg::DIST_W'(bpnc_pkg::WEIGHT_R)
              + bpnc_pkg::DIST_W'(sq_g_ff) * bpnc_pkg::DIST_W'(bpnc_pkg::WEIGHT_G)
              + bpnc_pkg::DIST_W'(sq_b_ff) * bpnc_pkg::DIST_W'(bpnc_pkg::WEIGHT_B);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= in_index;
      sq_r_ff     <= sq_r_in;
      sq_g_ff     <= sq_g_in;
      sq_b_ff     <= sq_b_in;
      s2_index_ff <= s1_index_ff;
      dist_ff     <= dist_in;
   end

   assign busy            = s1_valid_ff;
   assign result.valid    = s2_valid_ff;
   assign result.index    = s2_index_ff;
   assign result.distance = dist_ff;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the blended palette nearest colour unit. Requests
// (palette loads and blended queries) go in through a valid/stall channel
// that idles in random bursts. A behavioural copy of the palette predicts
// each response. Responses are drawn against a stall pattern with one long
// hold-off, and each is checked in order against the prediction.
// ============================================================================
module tb_top;

   localparam int unsigned PALETTE_N       = 256;
   // long receiver hold-off, long enough to fill the unit and back it up
   localparam int unsigned HOLD_OFF_CYCLES = 1500;
   // cycles with no request or response accepted before giving up
   localparam int unsigned IDLE_LIMIT      = 20000;
   // one full search plus its pipe, after the last expected response
   localparam int unsigned DRAIN_CYCLES    = PALETTE_N + 40;

   localparam bpnc_pkg::rgb_type COLOUR_BLACK = '0;
   localparam bpnc_pkg::rgb_type COLOUR_WHITE = '1;

   typedef struct packed {
      logic                         kind;
      logic [bpnc_pkg::INDEX_W-1:0] entry_index;
      bpnc_pkg::rgb_type            colour;
      logic [bpnc_pkg::INDEX_W-1:0] first_color;
      logic [bpnc_pkg::INDEX_W-1:0] second_color;
      logic                         blend_mode;
   } palette_request_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_style_type;

   // all inputs known from time zero
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic       req_kind         = bpnc_pkg::KIND_LOAD;
   logic [7:0] req_entry_index  = '0;
   logic [7:0] req_red          = '0;
   logic [7:0] req_green        = '0;
   logic [7:0] req_blue         = '0;
   logic [7:0] req_first_color  = '0;
   logic [7:0] req_second_color = '0;
   logic       req_blend_mode   = bpnc_pkg::BLEND_HALF;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic [7:0] rsp_nearest_color;

   // shadow of the palette, updated as each load is accepted
   bpnc_pkg::rgb_type palette_shadow [PALETTE_N];
   // nearest colour expected for each accepted query, oldest first
   logic [7:0]  expected_nearest [$];
   int unsigned mismatch_count   = 0;
   int unsigned idle_cycles      = 0;
   int          burst_left       = 0;
   bit          gaps_enabled     = 1'b1;
   bit          hold_off_request = 1'b0;

   blended_palette_nearest_color_unit #(
      .PALETTE_ENTRIES (PALETTE_N)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_first_color   (req_first_color),
      .req_second_color  (req_second_color),
      .req_blend_mode    (req_blend_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nearest_color (rsp_nearest_color)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // per component blend: half and half, or a quarter first and three
   // quarters second, both rounded down
   function automatic logic [7:0] blend_component(logic [7:0] a, logic [7:0] b,
                                                  logic mode);
      logic [9:0] sum;
      if (mode == bpnc_pkg::BLEND_QUARTER) begin
         sum = {2'b00, a} + 10'd3 * {2'b00, b};
         return sum[9:2];
      end
      sum = {2'b00, a} + {2'b00, b};
      return sum[8:1];
   endfunction

   function automatic logic [7:0] nearest_index(logic [7:0] first, logic [7:0] second,
                                                logic mode);
      bpnc_pkg::rgb_type ca, cb, target;
      int                dr, dg, db, distance, best_dist;
      logic [7:0]        best;
      // same colour twice: answered directly, no search
      if (first == second) return first;
      // indexes beyond the palette read as black
      ca = (first < PALETTE_N) ? palette_shadow[first] : COLOUR_BLACK;
      cb = (second < PALETTE_N) ? palette_shadow[second] : COLOUR_BLACK;
      target.r = blend_component(ca.r, cb.r, mode);
      target.g = blend_component(ca.g, cb.g, mode);
      target.b = blend_component(ca.b, cb.b, mode);
      best      = '0;
      best_dist = 0;
      for (int k = 0; k < PALETTE_N; k++) begin
         dr       = int'(palette_shadow[k].r) - int'(target.r);
         dg       = int'(palette_shadow[k].g) - int'(target.g);
         db       = int'(palette_shadow[k].b) - int'(target.b);
         distance = int'(bpnc_pkg::WEIGHT_R) * dr * dr
                  + int'(bpnc_pkg::WEIGHT_G) * dg * dg
                  + int'(bpnc_pkg::WEIGHT_B) * db * db;
         // strict less-than keeps the lowest index on a tie
         if (k == 0 || distance < best_dist) begin
            best_dist = distance;
            best      = 8'(k);
         end
      end
      return best;
   endfunction

   task automatic apply_request(input palette_request_type r);
      if (r.kind == bpnc_pkg::KIND_LOAD) begin
         // loads beyond the palette are dropped
         if (r.entry_index < PALETTE_N) palette_shadow[r.entry_index] = r.colour;
      end else begin
         expected_nearest.push_back(nearest_index(r.first_color, r.second_color,
                                                  r.blend_mode));
      end
   endtask

   // ------------------------------------------------------------------------
   // Request building; unused fields carry noise
   // ------------------------------------------------------------------------

   function automatic bpnc_pkg::rgb_type random_colour();
      bpnc_pkg::rgb_type c;
      c = 24'($urandom);
      // push components to the rails now and then
      if ($urandom_range(0, 4) == 0) c.r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 4) == 0) c.g = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 4) == 0) c.b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return c;
   endfunction

   function automatic palette_request_type make_load(logic [7:0] index,
                                                     bpnc_pkg::rgb_type c);
      palette_request_type r;
      r.kind         = bpnc_pkg::KIND_LOAD;
      r.entry_index  = index;
      r.colour       = c;
      r.first_color  = 8'($urandom);
      r.second_color = 8'($urandom);
      r.blend_mode   = 1'($urandom);
      return r;
   endfunction

   function automatic palette_request_type make_query(logic [7:0] first,
                                                      logic [7:0] second,
                                                      logic mode);
      palette_request_type r;
      r.kind         = bpnc_pkg::KIND_QUERY;
      r.entry_index  = 8'($urandom);
      r.colour       = 24'($urandom);
      r.first_color  = first;
      r.second_color = second;
      r.blend_mode   = mode;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side: drive at the falling edge, accept at the rising edge
   // ------------------------------------------------------------------------

   // bursts of random length, random gaps between them
   task automatic pace_sender();
      int gap;
      if (gaps_enabled) begin
         burst_left--;
         if (burst_left <= 0) begin
            // now and then a long unbroken burst
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
      end
   endtask

   task automatic send_request(input palette_request_type r);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_kind         <= r.kind;
      req_entry_index  <= r.entry_index;
      req_red          <= r.colour.r;
      req_green        <= r.colour.g;
      req_blue         <= r.colour.b;
      req_first_color  <= r.first_color;
      req_second_color <= r.second_color;
      req_blend_mode   <= r.blend_mode;
      // payload holds until the unit stops stalling
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      apply_request(r);
      pace_sender();
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // stall pattern of its own, in phases; a hold-off when asked for
   initial begin : receiver_pattern
      stall_style_type style;
      int              phase_len;
      forever begin
         if (hold_off_request) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            style     = stall_style_type'($urandom_range(0, 3));
            phase_len = $urandom_range(4, 60);
            repeat (phase_len) begin
               @(negedge clock);
               case (style)
                  STALL_NONE:  rsp_stall <= 1'b0;
                  STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY: rsp_stall <= ($urandom_range(0, 1) == 0);
                  default:     rsp_stall <= 1'b1;
               endcase
            end
         end
      end
   end

   task automatic report_mismatch(input string detail);
      $display("[%0t] mismatch: %s", $time, detail);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_nearest.size() == 0) begin
            report_mismatch($sformatf("response %0d with no query outstanding",
                                      rsp_nearest_color));
         end else begin
            if (rsp_nearest_color !== expected_nearest[0])
               report_mismatch($sformatf("nearest_color got %0d expected %0d",
                                         rsp_nearest_color, expected_nearest[0]));
            void'(expected_nearest.pop_front());
         end
      end
   end

   // watchdog: counts cycles with nothing accepted on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // same colour twice needs no search, so it is safe before any load
   task automatic test_same_colour_unloaded();
      send_request(make_query(8'd0, 8'd0, bpnc_pkg::BLEND_HALF));
      send_request(make_query(8'd255, 8'd255, bpnc_pkg::BLEND_QUARTER));
      send_request(make_query(8'h5A, 8'h5A, bpnc_pkg::BLEND_HALF));
   endtask

   // every entry written before the first search; black and primaries first, white last
   task automatic test_palette_fill();
      bpnc_pkg::rgb_type c;
      for (int k = 0; k < PALETTE_N; k++) begin
         case (k)
            0:             c = COLOUR_BLACK;
            1:             c = 24'hFF0000;
            2:             c = 24'h00FF00;
            3:             c = 24'h0000FF;
            PALETTE_N - 1: c = COLOUR_WHITE;
            default:       c = random_colour();
         endcase
         send_request(make_load(8'(k), c));
      end
   endtask

   task automatic test_directed_queries();
      bpnc_pkg::rgb_type tie_colour;
      tie_colour = 24'h102030;
      send_request(make_load(8'd10, COLOUR_WHITE));
      send_request(make_load(8'd11, COLOUR_BLACK));
      send_request(make_query(8'd10, 8'd11, bpnc_pkg::BLEND_HALF));
      send_request(make_query(8'd10, 8'd11, bpnc_pkg::BLEND_QUARTER));
      // quarter blend is not symmetric
      send_request(make_query(8'd11, 8'd10, bpnc_pkg::BLEND_QUARTER));
      // three entries with one colour: exact hit, lowest index wins the tie
      send_request(make_load(8'd40, tie_colour));
      send_request(make_load(8'd41, tie_colour));
      send_request(make_load(8'd200, tie_colour));
      send_request(make_query(8'd41, 8'd200, bpnc_pkg::BLEND_HALF));
      send_request(make_query(8'd200, 8'd40, bpnc_pkg::BLEND_QUARTER));
      // extreme indexes and primaries
      send_request(make_query(8'd0, 8'd255, bpnc_pkg::BLEND_HALF));
      send_request(make_query(8'd255, 8'd0, bpnc_pkg::BLEND_QUARTER));
      send_request(make_query(8'd1, 8'd2, bpnc_pkg::BLEND_QUARTER));
      send_request(make_query(8'd2, 8'd3, bpnc_pkg::BLEND_HALF));
      send_request(make_query(8'd7, 8'd7, bpnc_pkg::BLEND_QUARTER));
   endtask

   // mostly queries, loads keep the palette moving; copied colours make ties
   task automatic test_random_traffic();
      bpnc_pkg::rgb_type c;
      logic [7:0]        first;
      for (int n = 0; n < 660; n++) begin
         if ($urandom_range(0, 99) < 35) begin
            if ($urandom_range(0, 3) == 0) c = palette_shadow[$urandom_range(0, PALETTE_N - 1)];
            else                           c = random_colour();
            send_request(make_load(8'($urandom), c));
         end else begin
            first = 8'($urandom);
            send_request(make_query(first,
                                    ($urandom_range(0, 9) == 0) ? first : 8'($urandom),
                                    1'($urandom)));
         end
      end
   endtask

   // receiver holds off while requests keep coming, back to back
   task automatic test_receiver_hold_off();
      logic [7:0] first;
      gaps_enabled     = 1'b0;
      hold_off_request = 1'b1;
      for (int n = 0; n < 12; n++) begin
         first = 8'($urandom);
         send_request(make_query(first, (n % 3 == 0) ? first : 8'($urandom),
                                 1'($urandom)));
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_same_colour_unloaded();
      test_palette_fill();
      test_directed_queries();
      test_random_traffic();
      test_receiver_hold_off();

      // no more requests
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then allow a search's worth of time for anything stray
      while (expected_nearest.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- blended_palette_nearest_color_unit.f -----
hdl/bpnc_pkg.sv
hdl/bpnc_dist_pipe.sv
hdl/blended_palette_nearest_color_unit.sv
sim/tb_top.sv
